[src/mmfs_pkg.sv]
// mmfs_pkg: shared types and constants for the min-max feature scaler
// opcodes, controller states, command and status structs between ctrl and dpath
// no dependencies
package mmfs_pkg;

  // field widths
  localparam int DATA_W = 32;
  localparam int NORM_W = 17;
  localparam int FRAC_W = 16;
  localparam int COL_W  = 4;
  localparam int NF_W   = 5;
  localparam int OP_W   = 2;

  // per-column min/max table always has one entry per column code
  localparam int NUM_COLS = 16;

  // parameter defaults for the top level
  localparam int DEF_MAX_FEATURES = 16;
  localparam int DEF_MAX_SAMPLES  = 1024;

  // arithmetic widths
  localparam int DIFF_W    = DATA_W + 1;           // exact difference of two samples
  localparam int DVD_W     = DIFF_W + FRAC_W + 1;  // scaled and rounded dividend
  localparam int DIV_STEPS = NORM_W;               // one quotient bit per step
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int PROD_W    = NORM_W + DATA_W;
  localparam int SUM_W     = DIFF_W + 2;

  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // result codes
  localparam logic KIND_NORM    = 1'b0;
  localparam logic KIND_DENORM  = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_DRAIN  = 2'd1,
    OP_DENORM = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic load_exec;
    logic clear_exec;
    logic drain_rd;
    logic drain_none;
    logic den_none;
    logic mul;
    logic div_init;
    logic div_step;
    logic den_fin;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic drain_empty;
    logic col_empty;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

[src/mmfs_ram.sv]
// mmfs_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module mmfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/mmfs_ctrl.sv]
// mmfs_ctrl: sequencing state machine of the min-max feature scaler
// depends on mmfs_pkg; drives commands into mmfs_dpath and reads its status
module mmfs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mmfs_pkg::sts_t  sts,
  output mmfs_pkg::cmd_t  cmd
);
  import mmfs_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts.op)
          OP_LOAD: begin
            cmd.load_exec = 1'b1;
            state_nxt     = ST_IDLE;
          end
          OP_CLEAR: begin
            cmd.clear_exec = 1'b1;
            state_nxt      = ST_IDLE;
          end
          OP_DRAIN: begin
            if (sts.drain_empty) begin
              cmd.drain_none = 1'b1;
              state_nxt      = ST_OUT;
            end else begin
              cmd.drain_rd = 1'b1;
              state_nxt    = ST_FETCH;
            end
          end
          OP_DENORM: begin
            if (sts.col_empty) begin
              cmd.den_none = 1'b1;
              state_nxt    = ST_OUT;
            end else begin
              cmd.mul   = 1'b1;
              state_nxt = ST_FIN;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_FETCH: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_FIN: begin
        cmd.den_fin = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[src/mmfs_dpath.sv]
// mmfs_dpath: datapath of the min-max feature scaler
// value store, column min/max, counters, radix-2 divider, denormalize multiplier
// depends on mmfs_pkg and mmfs_ram; commanded by mmfs_ctrl
module mmfs_dpath #(
  parameter int MAX_FEATURES = mmfs_pkg::DEF_MAX_FEATURES,
  parameter int MAX_SAMPLES  = mmfs_pkg::DEF_MAX_SAMPLES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [mmfs_pkg::NF_W-1:0]          cfg_wr_data,
  input  logic [mmfs_pkg::OP_W-1:0]          in_opcode,
  input  logic signed [mmfs_pkg::DATA_W-1:0] in_sample_value,
  input  logic [mmfs_pkg::COL_W-1:0]         in_column_select,
  input  logic [mmfs_pkg::NORM_W-1:0]        in_norm_in,
  input  mmfs_pkg::cmd_t                     cmd,
  output mmfs_pkg::sts_t                     sts,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic                               out_result_kind,
  output logic [mmfs_pkg::NORM_W-1:0]        out_norm_out,
  output logic signed [mmfs_pkg::DATA_W-1:0] out_denorm_out,
  output logic [mmfs_pkg::COL_W-1:0]         out_column_out,
  output logic                               out_last_out,
  output logic                               out_status,
  output logic                               out_overflow
);
  import mmfs_pkg::*;

  localparam int STORE_DEPTH = MAX_FEATURES * MAX_SAMPLES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int MAX_NF      = (MAX_FEATURES < NUM_COLS) ? MAX_FEATURES : NUM_COLS;

  // column after c, wrapping at n columns
  function automatic logic [COL_W-1:0] next_col(input logic [COL_W-1:0] c,
                                                input logic [NF_W-1:0]  n);
    logic [NF_W-1:0] inc;
    inc = NF_W'(c) + NF_W'(1);
    if (inc == n) begin
      return '0;
    end
    return COL_W'(inc);
  endfunction

  // captured item
  op_t                      op_r;
  logic signed [DATA_W-1:0] sample_r;
  logic [COL_W-1:0]         csel_r;
  logic [NORM_W-1:0]        norm_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= op_t'(in_opcode);
      sample_r <= in_sample_value;
      csel_r   <= in_column_select;
      norm_r   <= in_norm_in;
    end
  end

  // column count and capacity, clamped at write time
  logic [NF_W-1:0]  nf_r, nf_new;
  logic [CNT_W-1:0] cap_r, cap_new;

  always_comb begin
    if (cfg_wr_data == '0) begin
      nf_new = NF_W'(1);
    end else if (cfg_wr_data > NF_W'(MAX_NF)) begin
      nf_new = NF_W'(MAX_NF);
    end else begin
      nf_new = cfg_wr_data;
    end
    cap_new = CNT_W'(MAX_SAMPLES * int'(nf_new));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nf_r  <= NF_W'(1);
      cap_r <= CNT_W'(MAX_SAMPLES);
    end else if (cfg_wr_en) begin
      nf_r  <= nf_new;
      cap_r <= cap_new;
    end
  end

  // set counters and sticky overflow
  logic             clear_set;
  logic             can_load;
  logic [CNT_W-1:0] load_cnt_r, drain_ptr_r;
  logic [COL_W-1:0] load_col_r, drain_col_r;
  logic             ovf_r;

  assign clear_set = cmd.clear_exec | cfg_wr_en;
  assign can_load  = (load_cnt_r < cap_r);

  always_ff @(posedge clk) begin
    if (!rst_n || clear_set) begin
      load_cnt_r  <= '0;
      drain_ptr_r <= '0;
      load_col_r  <= '0;
      drain_col_r <= '0;
      ovf_r       <= 1'b0;
    end else begin
      if (cmd.load_exec) begin
        if (can_load) begin
          load_cnt_r <= load_cnt_r + CNT_W'(1);
          load_col_r <= next_col(load_col_r, nf_r);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.drain_rd) begin
        drain_ptr_r <= drain_ptr_r + CNT_W'(1);
        drain_col_r <= next_col(drain_col_r, nf_r);
      end
    end
  end

  // staged result fields
  logic                     res_kind_r;
  logic [NORM_W-1:0]        res_norm_r;
  logic signed [DATA_W-1:0] res_denorm_r;
  logic [COL_W-1:0]         res_col_r;
  logic                     res_last_r;
  logic                     res_status_r;
  logic                     res_ovf_r;

  // column min/max table with one shared read index
  logic signed [DATA_W-1:0] col_min_r [NUM_COLS];
  logic signed [DATA_W-1:0] col_max_r [NUM_COLS];
  logic [COL_W-1:0]         col_idx;
  logic signed [DATA_W-1:0] sel_min, sel_max;

  always_comb begin
    case (op_r)
      OP_LOAD:   col_idx = load_col_r;
      OP_DENORM: col_idx = csel_r;
      default:   col_idx = res_col_r;
    endcase
  end

  assign sel_min = col_min_r[col_idx];
  assign sel_max = col_max_r[col_idx];

  always_ff @(posedge clk) begin
    if (!rst_n || clear_set) begin
      for (int i = 0; i < NUM_COLS; i++) begin
        col_min_r[i] <= DATA_MAX;
        col_max_r[i] <= DATA_MIN;
      end
    end else if (cmd.load_exec && can_load) begin
      if (sample_r < sel_min) begin
        col_min_r[col_idx] <= sample_r;
      end
      if (sample_r > sel_max) begin
        col_max_r[col_idx] <= sample_r;
      end
    end
  end

  // value store
  logic [DATA_W-1:0] rd_data;

  mmfs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.load_exec && can_load),
    .wr_addr (load_cnt_r[ADDR_W-1:0]),
    .wr_data (sample_r),
    .rd_en   (cmd.drain_rd),
    .rd_addr (drain_ptr_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // exact differences against the selected column
  logic [DIFF_W-1:0] x_num, rng_val;
  logic [DVD_W-1:0]  dvd;

  assign x_num   = {rd_data[DATA_W-1], rd_data} - {sel_min[DATA_W-1], sel_min};
  assign rng_val = {sel_max[DATA_W-1], sel_max} - {sel_min[DATA_W-1], sel_min};
  // (x - min) * 2^16 + floor(range / 2)
  assign dvd = DVD_W'({x_num, {FRAC_W{1'b0}}}) + DVD_W'(rng_val[DIFF_W-1:1]);

  // radix-2 restoring divider, one quotient bit per step
  logic [DIFF_W-1:0]    rem_r, rng_r;
  logic [NORM_W-1:0]    dlo_r, q_r, q_nxt;
  logic                 rng_zero_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [DIFF_W:0]      trial;
  logic                 q_bit;
  logic [DIFF_W-1:0]    rem_nxt;
  logic                 div_last;

  assign trial    = {rem_r, dlo_r[NORM_W-1]};
  assign q_bit    = (trial >= {1'b0, rng_r});
  assign rem_nxt  = q_bit ? DIFF_W'(trial - {1'b0, rng_r}) : trial[DIFF_W-1:0];
  assign q_nxt    = {q_r[NORM_W-2:0], q_bit};
  assign div_last = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r      <= dvd[DVD_W-1:NORM_W];
      dlo_r      <= dvd[NORM_W-1:0];
      rng_r      <= rng_val;
      rng_zero_r <= (rng_val == '0);
      q_r        <= '0;
      div_cnt_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r     <= rem_nxt;
      dlo_r     <= {dlo_r[NORM_W-2:0], 1'b0};
      q_r       <= q_nxt;
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  // denormalize: registered product, then round, add min and saturate
  logic [PROD_W-1:0]        prod_r, prod_rnd;
  logic signed [DATA_W-1:0] mn_r;
  logic [DIFF_W-1:0]        adj;
  logic [SUM_W-1:0]         den_sum;
  logic                     den_sat;
  logic signed [DATA_W-1:0] den_val;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(norm_r) * PROD_W'(rng_val[DATA_W-1:0]);
      mn_r   <= sel_min;
    end
  end

  assign prod_rnd = prod_r + PROD_W'(1 << (FRAC_W - 1));
  assign adj      = prod_rnd[PROD_W-1:FRAC_W];
  assign den_sum  = {{(SUM_W-DATA_W){mn_r[DATA_W-1]}}, mn_r} + {2'b00, adj};
  // sum never drops below min, so only the top end can saturate
  assign den_sat  = !den_sum[SUM_W-1] && (den_sum[SUM_W-2:DATA_W-1] != '0);
  assign den_val  = den_sat ? DATA_MAX : den_sum[DATA_W-1:0];

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.drain_none) begin
      res_kind_r   <= KIND_NORM;
      res_norm_r   <= '0;
      res_denorm_r <= '0;
      res_col_r    <= '0;
      res_last_r   <= 1'b0;
      res_status_r <= STATUS_EMPTY;
      res_ovf_r    <= ovf_r;
    end
    if (cmd.den_none) begin
      res_kind_r   <= KIND_DENORM;
      res_norm_r   <= '0;
      res_denorm_r <= '0;
      res_col_r    <= csel_r;
      res_last_r   <= 1'b0;
      res_status_r <= STATUS_EMPTY;
      res_ovf_r    <= ovf_r;
    end
    if (cmd.drain_rd) begin
      res_kind_r   <= KIND_NORM;
      res_denorm_r <= '0;
      res_col_r    <= drain_col_r;
      res_last_r   <= ((drain_ptr_r + CNT_W'(1)) == load_cnt_r);
      res_status_r <= STATUS_OK;
      res_ovf_r    <= ovf_r;
    end
    if (cmd.div_step && div_last) begin
      res_norm_r <= rng_zero_r ? '0 : q_nxt;
    end
    if (cmd.mul) begin
      res_kind_r   <= KIND_DENORM;
      res_norm_r   <= '0;
      res_col_r    <= csel_r;
      res_last_r   <= 1'b0;
      res_status_r <= STATUS_OK;
      res_ovf_r    <= ovf_r;
    end
    if (cmd.den_fin) begin
      res_denorm_r <= den_val;
    end
  end

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_result_kind <= res_kind_r;
      out_norm_out    <= res_norm_r;
      out_denorm_out  <= res_denorm_r;
      out_column_out  <= res_col_r;
      out_last_out    <= res_last_r;
      out_status      <= res_status_r;
      out_overflow    <= res_ovf_r;
    end
  end

  assign out_valid = out_valid_r;

  // status to the controller
  always_comb begin
    sts.op          = op_r;
    sts.drain_empty = (drain_ptr_r >= load_cnt_r);
    sts.col_empty   = (sel_min > sel_max);
    sts.div_last    = div_last;
    sts.out_free    = !out_valid_r || out_ready;
  end

endmodule

[src/min_max_feature_scaler_unit.sv]
// min_max_feature_scaler_unit: top level of the min-max feature scaler
// depends on mmfs_pkg, mmfs_ctrl, mmfs_dpath (which holds mmfs_ram)
//
// Loads signed Q16.16 values in row order (cfg_wr_data columns per sample,
// clamped to 1..min(MAX_FEATURES, 16)), keeps each column's minimum and maximum, and returns
// (x - min) / range as unsigned Q1.16 on drain, or norm * range + min on
// denormalize. A write on cfg_wr_en also clears the data set. One item is
// worked on at a time; a drain is paced by the radix-2 divider, which
// resolves one of the 17 quotient bits per cycle. Results sit in an
// output register, so the next item is taken while a result waits. The value
// store is a single-port-write RAM of MAX_FEATURES * MAX_SAMPLES words; it
// needs no clearing pass, and reads only entries below the load count.
module min_max_feature_scaler_unit #(
  parameter int MAX_FEATURES = mmfs_pkg::DEF_MAX_FEATURES,
  parameter int MAX_SAMPLES  = mmfs_pkg::DEF_MAX_SAMPLES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [mmfs_pkg::NF_W-1:0]          cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mmfs_pkg::OP_W-1:0]          in_opcode,
  input  logic signed [mmfs_pkg::DATA_W-1:0] in_sample_value,
  input  logic [mmfs_pkg::COL_W-1:0]         in_column_select,
  input  logic [mmfs_pkg::NORM_W-1:0]        in_norm_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_result_kind,
  output logic [mmfs_pkg::NORM_W-1:0]        out_norm_out,
  output logic signed [mmfs_pkg::DATA_W-1:0] out_denorm_out,
  output logic [mmfs_pkg::COL_W-1:0]         out_column_out,
  output logic                               out_last_out,
  output logic                               out_status,
  output logic                               out_overflow
);
  import mmfs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  mmfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and arithmetic
  mmfs_dpath #(
    .MAX_FEATURES (MAX_FEATURES),
    .MAX_SAMPLES  (MAX_SAMPLES)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_opcode        (in_opcode),
    .in_sample_value  (in_sample_value),
    .in_column_select (in_column_select),
    .in_norm_in       (in_norm_in),
    .cmd              (cmd),
    .sts              (sts),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_result_kind  (out_result_kind),
    .out_norm_out     (out_norm_out),
    .out_denorm_out   (out_denorm_out),
    .out_column_out   (out_column_out),
    .out_last_out     (out_last_out),
    .out_status       (out_status),
    .out_overflow     (out_overflow)
  );

endmodule

[sim/testbench.sv]
// testbench: self-checking bench for min_max_feature_scaler_unit
// checks every transfer on the result channel against a scaling predictor held in this file
// depends on mmfs_pkg and the scaler rtl only
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mmfs_pkg::*;

  localparam int STORE_WORDS   = DEF_MAX_FEATURES * DEF_MAX_SAMPLES;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_REPORTS   = 10;

  // one result transfer, field by field
  typedef struct packed {
    logic              kind;
    logic [NORM_W-1:0] norm;
    logic [DATA_W-1:0] denorm;
    logic [COL_W-1:0]  col;
    logic              last;
    logic              status;
    logic              ovf;
  } scaled_t;

  // one row of the directed stimulus table
  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] sample;
    logic [COL_W-1:0]         sel;
    logic [NORM_W-1:0]        nrm;
    logic                     typed;
    scaled_t                  want;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_wr_en;
  logic [NF_W-1:0]          cfg_wr_data;
  logic                     in_valid;
  logic                     in_ready;
  logic [OP_W-1:0]          in_opcode;
  logic signed [DATA_W-1:0] in_sample_value;
  logic [COL_W-1:0]         in_column_select;
  logic [NORM_W-1:0]        in_norm_in;
  logic                     out_valid;
  logic                     out_ready;
  logic                     out_result_kind;
  logic [NORM_W-1:0]        out_norm_out;
  logic signed [DATA_W-1:0] out_denorm_out;
  logic [COL_W-1:0]         out_column_out;
  logic                     out_last_out;
  logic                     out_status;
  logic                     out_overflow;

  min_max_feature_scaler_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_sample_value  (in_sample_value),
    .in_column_select (in_column_select),
    .in_norm_in       (in_norm_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_norm_out     (out_norm_out),
    .out_denorm_out   (out_denorm_out),
    .out_column_out   (out_column_out),
    .out_last_out     (out_last_out),
    .out_status       (out_status),
    .out_overflow     (out_overflow)
  );

  // clock
  always #5 clk = ~clk;

  // predictor state: stored samples, per-column bounds, counters, register
  int              stored_val [STORE_WORDS];
  int              col_lo [NUM_COLS];
  int              col_hi [NUM_COLS];
  int unsigned     n_loaded;
  int unsigned     n_drained;
  int unsigned     next_col;
  bit              ovf_seen;
  logic [NF_W-1:0] feat_reg;

  scaled_t expected_q [$];

  int  mismatches;
  int  items_sent;
  int  drain_results;
  int  denorm_results;
  int  settings_used;
  int  overflow_hits;
  bit  no_idle;
  bit  hold_req;

  // effective column count after clamping the register
  function automatic int unsigned active_features();
    int unsigned n;
    n = feat_reg;
    if (n == 0) n = 1;
    if (n > DEF_MAX_FEATURES) n = DEF_MAX_FEATURES;
    return n;
  endfunction

  // empty the data set
  function automatic void reset_set();
    for (int c = 0; c < NUM_COLS; c++) begin
      col_lo[c] = DATA_MAX;
      col_hi[c] = DATA_MIN;
    end
    n_loaded  = 0;
    n_drained = 0;
    next_col  = 0;
    ovf_seen  = 1'b0;
  endfunction

  // expected outcome of one accepted item, updating predictor state
  task automatic scale_predict(input op_t op, input int sample, input logic [COL_W-1:0] sel,
                               input logic [NORM_W-1:0] nrm, output bit produced,
                               output scaled_t r);
    int unsigned     n, c, p;
    longint          lo, hi, span, v;
    longint unsigned uspan, num, q, prod;
    n = active_features();
    r = '0;
    produced = 1'b0;
    case (op)
      OP_LOAD: begin
        if (n_loaded < DEF_MAX_SAMPLES * n) begin
          c = next_col % n;
          stored_val[n_loaded] = sample;
          if (sample < col_lo[c]) col_lo[c] = sample;
          if (sample > col_hi[c]) col_hi[c] = sample;
          n_loaded++;
          next_col = (c + 1) % n;
        end else begin
          ovf_seen = 1'b1;
          overflow_hits++;
        end
      end
      OP_CLEAR: begin
        reset_set();
      end
      OP_DRAIN: begin
        produced = 1'b1;
        r.kind = KIND_NORM;
        r.ovf  = ovf_seen;
        if (n_drained >= n_loaded) begin
          r.status = STATUS_EMPTY;
        end else begin
          p    = n_drained;
          c    = p % n;
          v    = stored_val[p];
          lo   = col_lo[c];
          span = longint'(col_hi[c]) - lo;
          q    = 0;
          if (span > 0) begin
            uspan = span;
            num   = v - lo;
            q     = ((num << 16) + (uspan >> 1)) / uspan;
            if (q > 65536) q = 65536;
          end
          r.norm    = q[NORM_W-1:0];
          r.col     = c[COL_W-1:0];
          r.last    = (p + 1 == n_loaded);
          r.status  = STATUS_OK;
          n_drained = p + 1;
        end
      end
      default: begin
        produced = 1'b1;
        r.kind = KIND_DENORM;
        r.ovf  = ovf_seen;
        r.col  = sel;
        lo = col_lo[sel];
        hi = col_hi[sel];
        if (lo > hi) begin
          r.status = STATUS_EMPTY;
        end else begin
          if (hi == lo) begin
            v = lo;
          end else begin
            uspan = hi - lo;
            prod  = longint'(nrm) * uspan;
            v     = lo + longint'((prod + 32768) >> 16);
          end
          if (v > longint'(DATA_MAX)) v = DATA_MAX;
          if (v < longint'(DATA_MIN)) v = DATA_MIN;
          r.denorm = v[DATA_W-1:0];
          r.status = STATUS_OK;
        end
      end
    endcase
  endtask

  function automatic int idle_draw();
    if (no_idle) return 0;
    return $urandom_range(0, 14);
  endfunction

  // offer one item, hold it until the transfer, then record what it should cause
  task automatic offer_item(input op_t op, input int sample, input logic [COL_W-1:0] sel,
                            input logic [NORM_W-1:0] nrm, input bit typed, input scaled_t want);
    int      gap;
    bit      produced;
    scaled_t pred;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_sample_value  <= sample;
    in_column_select <= sel;
    in_norm_in       <= nrm;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scale_predict(op, sample, sel, nrm, produced, pred);
    if (produced) expected_q.push_back(typed ? want : pred);
    items_sent++;
  endtask

  task automatic offer(input op_t op, input int sample, input logic [COL_W-1:0] sel,
                       input logic [NORM_W-1:0] nrm);
    offer_item(op, sample, sel, nrm, 1'b0, '0);
  endtask

  // let the block go idle, then write the column count
  task automatic write_features(input logic [NF_W-1:0] value);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    feat_reg = value;
    reset_set();
    settings_used++;
    cfg_wr_en <= 1'b0;
  endtask

  // sample values: extremes, narrow clusters, full random
  function automatic int pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return DATA_MIN;
    if (r == 1) return DATA_MAX;
    if (r < 6) return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    return $urandom;
  endfunction

  function automatic logic [NORM_W-1:0] pick_norm();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return 17'd65536;
    if (r == 2) return NORM_W'($urandom_range(65537, 131071));
    return NORM_W'($urandom_range(0, 65536));
  endfunction

  function automatic logic [COL_W-1:0] pick_col(input int unsigned n);
    if ($urandom_range(0, 3) != 0) return COL_W'($urandom_range(0, n - 1));
    return COL_W'($urandom_range(0, NUM_COLS - 1));
  endfunction

  task automatic random_query(input int unsigned n);
    if ($urandom_range(0, 1) == 0) offer(OP_DRAIN, $urandom, COL_W'($urandom), NORM_W'($urandom));
    else offer(OP_DENORM, $urandom, pick_col(n), pick_norm());
  endtask

  // data sets: whole samples, sometimes plus a partial one, loaded with stray queries, drained, denormalized
  task automatic run_random_phase(input logic [NF_W-1:0] value, input int target,
                                  input bit with_hold);
    int          start;
    int unsigned n;
    int          n_load;
    int          pending;
    write_features(value);
    n = active_features();
    start = items_sent;
    while (items_sent - start < target) begin
      n_load = n * $urandom_range(1, (n > 8) ? 1 : 3);
      if ($urandom_range(0, 3) == 0) n_load += $urandom_range(0, n - 1);
      for (int k = 0; k < n_load; k++) begin
        if ($urandom_range(0, 9) == 0) random_query(n);
        offer(OP_LOAD, pick_sample(), COL_W'($urandom), NORM_W'($urandom));
      end
      if (with_hold) begin
        hold_req  = 1'b1;
        with_hold = 1'b0;
      end
      // drain everything left, one past the end
      pending = n_loaded - n_drained;
      for (int k = 0; k <= pending; k++) begin
        if ($urandom_range(0, 7) == 0) offer(OP_DENORM, $urandom, pick_col(n), pick_norm());
        offer(OP_DRAIN, $urandom, COL_W'($urandom), NORM_W'($urandom));
      end
      repeat ($urandom_range(2, 6)) offer(OP_DENORM, $urandom, pick_col(n), pick_norm());
      if ($urandom_range(0, 1) == 0) begin
        offer(OP_CLEAR, $urandom, COL_W'($urandom), NORM_W'($urandom));
      end
    end
  endtask

  function automatic scaled_t outcome(input logic kind, input logic [NORM_W-1:0] norm,
                                      input logic [DATA_W-1:0] denorm,
                                      input logic [COL_W-1:0] col, input logic last,
                                      input logic status);
    scaled_t r;
    r.kind   = kind;
    r.norm   = norm;
    r.denorm = denorm;
    r.col    = col;
    r.last   = last;
    r.status = status;
    r.ovf    = 1'b0;
    return r;
  endfunction

  function automatic dir_row_t step_of(input op_t op, input logic [DATA_W-1:0] sample,
                                       input logic [COL_W-1:0] sel,
                                       input logic [NORM_W-1:0] nrm, input logic typed,
                                       input scaled_t want);
    dir_row_t d;
    d.op     = op;
    d.sample = sample;
    d.sel    = sel;
    d.nrm    = nrm;
    d.typed  = typed;
    d.want   = want;
    return d;
  endfunction

  task automatic log_mismatch(input string what, input scaled_t want, input scaled_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t mismatch (%s)", $realtime, what);
      $display("  expected kind %0d norm %0d denorm %0d col %0d last %0d status %0d ovf %0d",
               want.kind, want.norm, $signed(want.denorm), want.col, want.last, want.status,
               want.ovf);
      $display("  actual   kind %0d norm %0d denorm %0d col %0d last %0d status %0d ovf %0d",
               got.kind, got.norm, $signed(got.denorm), got.col, got.last, got.status,
               got.ovf);
    end
  endtask

  // result side: random back-pressure, one long hold on request, compare each transfer
  initial begin
    int      stall;
    scaled_t got;
    scaled_t want;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = idle_draw();
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.kind   = out_result_kind;
      got.norm   = out_norm_out;
      got.denorm = out_denorm_out;
      got.col    = out_column_out;
      got.last   = out_last_out;
      got.status = out_status;
      got.ovf    = out_overflow;
      if (got.kind == KIND_NORM) drain_results++;
      else denorm_results++;
      if (expected_q.size() == 0) begin
        log_mismatch("result with nothing expected", '0, got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) log_mismatch("field mismatch", want, got);
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // stimulus
  initial begin
    dir_row_t dir_tab [$];
    dir_row_t d;
    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    in_valid         <= 1'b0;
    in_opcode        <= OP_LOAD;
    in_sample_value  <= '0;
    in_column_select <= '0;
    in_norm_in       <= '0;
    feat_reg = 5'd1;
    reset_set();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, one column after reset
    dir_tab.push_back(step_of(OP_DRAIN, 0, 0, 0, 1,
                              outcome(KIND_NORM, 0, 0, 0, 0, STATUS_EMPTY)));
    dir_tab.push_back(step_of(OP_DENORM, 0, 0, 17'd100, 1,
                              outcome(KIND_DENORM, 0, 0, 0, 0, STATUS_EMPTY)));
    dir_tab.push_back(step_of(OP_DENORM, '1, 4'd15, '1, 1,
                              outcome(KIND_DENORM, 0, 0, 4'd15, 0, STATUS_EMPTY)));
    dir_tab.push_back(step_of(OP_LOAD, DATA_MIN, '1, '1, 0, '0));
    dir_tab.push_back(step_of(OP_LOAD, DATA_MAX, 0, 0, 0, '0));
    dir_tab.push_back(step_of(OP_LOAD, 0, 0, 0, 0, '0));
    dir_tab.push_back(step_of(OP_DENORM, 0, 0, 0, 1,
                              outcome(KIND_DENORM, 0, DATA_MIN, 0, 0, STATUS_OK)));
    dir_tab.push_back(step_of(OP_DENORM, 0, 0, 17'd65536, 1,
                              outcome(KIND_DENORM, 0, DATA_MAX, 0, 0, STATUS_OK)));
    // norm above one saturates high
    dir_tab.push_back(step_of(OP_DENORM, 0, 0, '1, 1,
                              outcome(KIND_DENORM, 0, DATA_MAX, 0, 0, STATUS_OK)));
    // column past the configured count holds nothing
    dir_tab.push_back(step_of(OP_DENORM, 0, 4'd1, 17'd65536, 1,
                              outcome(KIND_DENORM, 0, 0, 4'd1, 0, STATUS_EMPTY)));
    dir_tab.push_back(step_of(OP_DRAIN, 0, 0, 0, 1,
                              outcome(KIND_NORM, 0, 0, 0, 0, STATUS_OK)));
    dir_tab.push_back(step_of(OP_DRAIN, 0, 0, 0, 1,
                              outcome(KIND_NORM, 17'd65536, 0, 0, 0, STATUS_OK)));
    dir_tab.push_back(step_of(OP_DRAIN, 0, 0, 0, 0, '0));
    dir_tab.push_back(step_of(OP_DRAIN, 0, 0, 0, 1,
                              outcome(KIND_NORM, 0, 0, 0, 0, STATUS_EMPTY)));
    dir_tab.push_back(step_of(OP_CLEAR, '1, '1, '1, 0, '0));
    // equal values give a zero range
    dir_tab.push_back(step_of(OP_LOAD, 32'sh0005_0000, 0, 0, 0, '0));
    dir_tab.push_back(step_of(OP_LOAD, 32'sh0005_0000, 0, 0, 0, '0));
    dir_tab.push_back(step_of(OP_DRAIN, 0, 0, 0, 1,
                              outcome(KIND_NORM, 0, 0, 0, 0, STATUS_OK)));
    dir_tab.push_back(step_of(OP_DENORM, 0, 0, 17'd40000, 1,
                              outcome(KIND_DENORM, 0, 32'sh0005_0000, 0, 0, STATUS_OK)));
    // load after draining began widens the range
    dir_tab.push_back(step_of(OP_LOAD, -3, 0, 0, 0, '0));
    dir_tab.push_back(step_of(OP_DRAIN, 0, 0, 0, 0, '0));
    dir_tab.push_back(step_of(OP_DENORM, 0, 0, 17'd1, 0, '0));
    dir_tab.push_back(step_of(OP_CLEAR, 0, 0, 0, 0, '0));
    dir_tab.push_back(step_of(OP_DRAIN, 0, 0, 0, 1,
                              outcome(KIND_NORM, 0, 0, 0, 0, STATUS_EMPTY)));
    foreach (dir_tab[i]) begin
      d = dir_tab[i];
      offer_item(d.op, d.sample, d.sel, d.nrm, d.typed, d.want);
    end

    // random part over several column counts, out-of-range codes included
    run_random_phase(5'd16, 80, 1'b1);
    run_random_phase(5'd0, 40, 1'b0);
    run_random_phase(5'd31, 40, 1'b0);
    run_random_phase(5'd17, 30, 1'b0);
    no_idle = 1'b1;
    run_random_phase(5'd3, 60, 1'b0);

    // short one-column set, loads back to back, then mixed queries
    write_features(5'd1);
    for (int k = 0; k < 6; k++) offer(OP_LOAD, pick_sample(), 0, 0);
    no_idle = 1'b0;
    repeat (3) offer(OP_DRAIN, 0, 0, 0);
    offer(OP_DENORM, 0, 0, pick_norm());
    offer(OP_LOAD, pick_sample(), 0, 0);
    offer(OP_DENORM, 0, 0, pick_norm());
    // a register write clears the set
    write_features(5'd1);
    offer(OP_DRAIN, 0, 0, 0);
    offer(OP_DENORM, 0, 0, pick_norm());

    repeat (2) run_random_phase(NF_W'($urandom_range(1, 16)), 40, 1'b0);

    // drain out and let the block settle
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d items over %0d column settings, %0d store overflow drops",
             items_sent, settings_used, overflow_hits);
    $display("checked %0d normalized and %0d denormalized results, %0d mismatches",
             drain_results, denorm_results, mismatches);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
src/mmfs_pkg.sv
src/mmfs_ram.sv
src/mmfs_ctrl.sv
src/mmfs_dpath.sv
src/min_max_feature_scaler_unit.sv
sim/testbench.sv
